// ===== sv/fwt_pkg.sv =====
`default_nettype none

package fwt_pkg;

    // Port field widths
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int RES_W  = 32;

    // Walk position: one bit above the index so that an update chain can step past the top
    localparam int POS_W  = IDX_W + 1;

    // Default sizes
    localparam int DEF_TREE_DEPTH = 1024;
    localparam int DEF_WORD_WIDTH = 32;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PREFIX = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RANGE  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  index;
        logic [IDX_W-1:0]  upper_index;
        logic [VAL_W-1:0]  value;
    } t_item;

endpackage

`default_nettype wire

// ===== sv/fwt_if.sv =====
`default_nettype none

interface fwt_in_if import fwt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  index;
    logic [IDX_W-1:0]  upper_index;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output func, output index, output upper_index,
                    output value, input ready);
    modport sink   (input valid, input func, input index, input upper_index,
                    input value, output ready);
endinterface

interface fwt_out_if import fwt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== sv/xor_fenwick_tree.sv =====
`default_nettype none

// Channel  Dir  Interface   Payload
// i_in     in   fwt_in_if   func[1:0], index[9:0], upper_index[9:0], value[31:0]
// o_out    out  fwt_out_if  result[31:0]
//
// One word at a time through a simple dual-port tree store (1 write, 1 read/cycle,
// registered read). Update: up to log2(TREE_DEPTH) read/write-back steps.
// Prefix query: one read per set bit of index; range query walks both chains,
// upper_index first, then index; an empty range returns zero without a walk.
// After reset a clearing pass writes zeros to all TREE_DEPTH entries, one per cycle;
// i_in.ready stays low until the pass is done.
// The result sits in an output register, so the next word is taken while o_out stalls.

module xor_fenwick_tree import fwt_pkg::*; #(
    parameter int TREE_DEPTH = DEF_TREE_DEPTH,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fwt_in_if.sink     i_in,
    fwt_out_if.source  o_out
);

    t_item             w_item;
    logic              w_ready;
    logic              w_start;
    logic              w_res_valid;
    logic              w_take;
    logic [RES_W-1:0]  w_result;

    // output stage
    logic              r_out_valid;
    logic [RES_W-1:0]  r_out_result;

    assign w_item.func        = i_in.func;
    assign w_item.index       = i_in.index;
    assign w_item.upper_index = i_in.upper_index;
    assign w_item.value       = i_in.value;

    assign i_in.ready = w_ready;
    assign w_start    = i_in.valid && w_ready;

    fwt_core #(
        .TREE_DEPTH (TREE_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (w_item),
        .o_ready     (w_ready),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_take),
        .o_result    (w_result)
    );

    // finished result moves over whenever the output register is free or draining
    assign w_take = w_res_valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_result <= w_result;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_out_result;

endmodule

`default_nettype wire

// ===== sv/fwt_core.sv =====
`default_nettype none

module fwt_core import fwt_pkg::*; #(
    parameter int TREE_DEPTH = DEF_TREE_DEPTH,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_item            i_item,
    output logic                  o_ready,
    output logic                  o_res_valid,
    input  wire logic             i_res_take,
    output logic [RES_W-1:0]      o_result
);

    localparam int          AW      = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
    // walk position must hold the first step past the top of any store depth
    localparam int          PW      = (AW + 1 > POS_W) ? AW + 1 : POS_W;
    localparam logic [31:0] DEPTH_L = 32'(TREE_DEPTH);
    localparam logic [AW-1:0] LAST  = AW'(TREE_DEPTH - 1);

    typedef enum logic [4:0] {
        ST_CLR  = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_QRY  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr, n_clr;
    logic [PW-1:0]         r_pos, n_pos;
    logic [IDX_W-1:0]      r_lo, n_lo;
    logic                  r_more, n_more;
    logic                  r_pend, n_pend;
    logic [AW-1:0]         r_wpos, n_wpos;
    logic [WORD_WIDTH-1:0] r_val, n_val;
    logic [WORD_WIDTH-1:0] r_acc, n_acc;

    // tree store
    logic [WORD_WIDTH-1:0] r_mem [TREE_DEPTH];
    logic [WORD_WIDTH-1:0] r_rd_data;

    logic                  w_we, w_re;
    logic [AW-1:0]         w_wa, w_ra;
    logic [WORD_WIDTH-1:0] w_wd;
    logic                  w_live;

    // position exists in the store
    assign w_live = (32'(r_pos) < DEPTH_L);
    assign w_ra   = AW'(r_pos);

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_pos   = r_pos;
        n_lo    = r_lo;
        n_more  = r_more;
        n_pend  = r_pend;
        n_wpos  = r_wpos;
        n_val   = r_val;
        n_acc   = r_acc;
        w_we    = 1'b0;
        w_wa    = r_wpos;
        w_wd    = r_rd_data ^ r_val;
        w_re    = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                w_we  = 1'b1;
                w_wa  = r_clr;
                w_wd  = '0;
                n_clr = r_clr + AW'(1);
                if (r_clr == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_acc  = '0;
                    n_pend = 1'b0;
                    n_more = 1'b0;
                    n_val  = WORD_WIDTH'(i_item.value);
                    n_pos  = PW'(i_item.index);
                    n_lo   = i_item.index;
                    case (i_item.func)
                        FUNC_UPDATE: n_state = ST_UPD;
                        FUNC_PREFIX: n_state = ST_QRY;
                        FUNC_RANGE: begin
                            if (i_item.index < i_item.upper_index) begin
                                n_pos   = PW'(i_item.upper_index);
                                n_more  = 1'b1;
                                n_state = ST_QRY;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_UPD: begin
                // write back the word read last cycle while the next one is fetched
                w_we = r_pend;
                if ((r_pos != '0) && w_live) begin
                    w_re   = 1'b1;
                    n_pend = 1'b1;
                    n_wpos = AW'(r_pos);
                    n_pos  = r_pos + (r_pos & (~r_pos + PW'(1)));
                end else begin
                    n_pend  = 1'b0;
                    n_state = ST_DONE;
                end
            end
            ST_QRY: begin
                if (r_pend) begin
                    n_acc = r_acc ^ r_rd_data;
                end
                if (r_pos != '0) begin
                    w_re   = w_live;
                    n_pend = w_live;
                    n_pos  = r_pos & (r_pos - PW'(1));
                end else begin
                    n_pend = 1'b0;
                    if (r_more) begin
                        // second chain of a range query
                        n_pos  = PW'(r_lo);
                        n_more = 1'b0;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_more  <= n_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_lo   <= n_lo;
        r_wpos <= n_wpos;
        r_val  <= n_val;
        r_acc  <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_result    = RES_W'(r_acc);

`ifndef SYNTH
    // a chain never reads the entry it writes back in the same cycle
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re && (w_wa == w_ra) && (r_state == ST_UPD)))
        else $error("read and write of the same entry in one cycle");

    // pending data always comes from a read issued the cycle before
    a_pend_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(w_re))
        else $error("pending word without a read");

    // update chain climbs strictly
    a_upd_climbs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && r_pend && $past(r_state == ST_UPD) && $past(r_pend))
        |-> (r_wpos > $past(r_wpos)))
        else $error("update chain does not climb");

    // store is only written by the clearing pass or an update walk
    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_CLR || r_state == ST_UPD))
        else $error("store written outside clear or update");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_fwt_monitor.sv =====
`timescale 1ns / 1ps

// Watches both channels and keeps a copy of the XOR Fenwick tree.
// Each accepted input word is turned into its expected result at once;
// results must come back in order.
module tb_fwt_monitor import fwt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fwt_in_if         i_in,
    fwt_out_if        i_out,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int TREE_DEPTH = DEF_TREE_DEPTH;

    logic [RES_W-1:0] xor_tree [TREE_DEPTH];
    logic [RES_W-1:0] expected_results [$];

    // XOR v into every word on the upward chain that stays below the depth
    function automatic void tree_xor_in(int unsigned pos, logic [RES_W-1:0] v);
        while (pos != 0 && pos < TREE_DEPTH) begin
            xor_tree[pos] ^= v;
            pos += pos & (~pos + 1);
        end
    endfunction

    // positions at or past the depth count as zero words
    function automatic logic [RES_W-1:0] tree_prefix_xor(int unsigned pos);
        logic [RES_W-1:0] acc;
        acc = '0;
        while (pos != 0) begin
            if (pos < TREE_DEPTH)
                acc ^= xor_tree[pos];
            pos &= pos - 1;
        end
        return acc;
    endfunction

    function automatic logic [RES_W-1:0] tree_result(t_item w);
        logic [RES_W-1:0] r;
        r = '0;
        case (w.func)
            FUNC_UPDATE: tree_xor_in(w.index, w.value);
            FUNC_PREFIX: r = tree_prefix_xor(w.index);
            FUNC_RANGE: begin
                if (w.index < w.upper_index)
                    r = tree_prefix_xor(w.upper_index) ^ tree_prefix_xor(w.index);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_item            word_in;
        logic [RES_W-1:0] want;
        if (!i_rst_n) begin
            for (int k = 0; k < TREE_DEPTH; k++)
                xor_tree[k] = '0;
            expected_results.delete();
        end else begin
            // compare first: a result can never belong to a word taken at this edge
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $realtime, i_out.result);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.result !== want) begin
                        o_fail_count++;
                        $display("%0t: result mismatch, expected %h, got %h",
                                 $realtime, want, i_out.result);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                word_in.func        = i_in.func;
                word_in.index       = i_in.index;
                word_in.upper_index = i_in.upper_index;
                word_in.value       = i_in.value;
                expected_results.push_back(tree_result(word_in));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_xor_fenwick_tree.sv =====
`timescale 1ns / 1ps

// Top of the XOR Fenwick tree bench: clock, reset, stimulus on the input
// channel, back-pressure on the output channel, watchdog and verdict.
// All result checking lives in tb_fwt_monitor.
module tb_xor_fenwick_tree;
    import fwt_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_WORDS   = 1350;
    localparam int HOLD_START     = 400;   // word count where the long output stall begins
    localparam int HOLD_WORDS     = 60;    // words offered back to back around the stall
    localparam int HOLD_CYCLES    = 300;   // long output stall, far past one walk
    localparam int QUIET_WORDS    = 150;   // tail of the run with no idling at all
    localparam int DRAIN_CYCLES   = 40;    // margin after the last result is back
    // Longest legal quiet stretch is the clearing pass or the long stall
    // plus one walk; take it several times over.
    localparam int WATCHDOG_LIMIT = 8000;

    // func code with no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;

    fwt_in_if  in_if ();
    fwt_out_if out_if ();

    int fail_count;
    int pending_results;

    // knobs shared between the sender and the receiver processes
    bit hold_req;     // ask the receiver for its one long stall
    bit back_to_back; // sender offers words without gaps
    bit quiet;        // no idling on either side

    xor_fenwick_tree u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    tb_fwt_monitor u_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic t_item make_word(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                                        logic [IDX_W-1:0] up, logic [VAL_W-1:0] v);
        t_item w;
        w.func        = f;
        w.index       = idx;
        w.upper_index = up;
        w.value       = v;
        return w;
    endfunction

    // Index mix: fully random, small, around powers of two (long chains),
    // and near the top (update chains that run off the end).
    function automatic logic [IDX_W-1:0] pick_index();
        logic [IDX_W-1:0] idx;
        case ($urandom_range(0, 3))
            0:       idx = IDX_W'($urandom);
            1:       idx = IDX_W'($urandom_range(0, 15));
            2:       idx = (IDX_W'(1) << $urandom_range(0, IDX_W - 1))
                           - IDX_W'($urandom_range(0, 1));
            default: idx = IDX_W'($urandom_range(1008, 1023));
        endcase
        return idx;
    endfunction

    function automatic t_item random_word();
        t_item            w;
        int               pick;
        logic [IDX_W-1:0] swap;
        pick          = $urandom_range(0, 99);
        w.index       = pick_index();
        w.upper_index = pick_index();
        case ($urandom_range(0, 7))
            0:       w.value = '0;
            1:       w.value = '1;
            default: w.value = $urandom;
        endcase
        if (pick < 35)
            w.func = FUNC_UPDATE;
        else if (pick < 60)
            w.func = FUNC_PREFIX;
        else if (pick < 95)
            w.func = FUNC_RANGE;
        else
            w.func = FUNC_SPARE;
        // most ranges are non-empty so both chains get walked
        if (w.func == FUNC_RANGE && w.index > w.upper_index && $urandom_range(0, 3) != 0) begin
            swap          = w.index;
            w.index       = w.upper_index;
            w.upper_index = swap;
        end
        return w;
    endfunction

    // Offer one word and hold it until taken; maybe idle afterwards.
    // valid is only ever assigned once per edge.
    task automatic send_word(input t_item w);
        in_if.valid       <= 1'b1;
        in_if.func        <= w.func;
        in_if.index       <= w.index;
        in_if.upper_index <= w.upper_index;
        in_if.value       <= w.value;
        do @(posedge i_clk); while (!in_if.ready);
        if (!quiet && !back_to_back && $urandom_range(0, 2) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Receiver: random stall bursts, ready stretches, and one long hold-off.
    initial begin : out_ready_gen
        bit hold_done;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                // block fills: result register stays full, input ready drops
                hold_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: cycles with no word moving on either channel.
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $realtime, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        hold_req     = 1'b0;
        back_to_back = 1'b0;
        quiet        = 1'b0;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.func        <= FUNC_UPDATE;
        in_if.index       <= '0;
        in_if.upper_index <= '0;
        in_if.value       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the tree starts empty after the clearing pass.
        send_word(make_word(FUNC_PREFIX, 10'd0,    10'd0,    32'h0));
        send_word(make_word(FUNC_PREFIX, 10'd1023, 10'd0,    32'h0));
        // update at index zero is dropped
        send_word(make_word(FUNC_UPDATE, 10'd0,    10'd0,    32'hFFFF_FFFF));
        send_word(make_word(FUNC_PREFIX, 10'd1023, 10'd0,    32'h0));
        // upper_index is don't-care for updates and prefixes
        send_word(make_word(FUNC_UPDATE, 10'd1,    10'd1023, 32'hFFFF_FFFF));
        send_word(make_word(FUNC_UPDATE, 10'd1023, 10'd0,    32'hA5A5_A5A5));
        // chain 768 -> 1024 runs off the top
        send_word(make_word(FUNC_UPDATE, 10'd768,  10'd0,    32'h8000_0001));
        send_word(make_word(FUNC_UPDATE, 10'd512,  10'd0,    32'h0000_FFFF));
        send_word(make_word(FUNC_UPDATE, 10'd1000, 10'd0,    $urandom));
        send_word(make_word(FUNC_PREFIX, 10'd1,    10'd0,    32'h0));
        send_word(make_word(FUNC_PREFIX, 10'd1023, 10'd5,    32'hFFFF_FFFF));
        send_word(make_word(FUNC_PREFIX, 10'd512,  10'd0,    32'h0));
        send_word(make_word(FUNC_PREFIX, 10'd767,  10'd0,    32'h0));
        send_word(make_word(FUNC_PREFIX, 10'd768,  10'd0,    32'h0));
        send_word(make_word(FUNC_RANGE,  10'd0,    10'd1023, 32'h0));
        // empty ranges: lower above upper, and equal bounds
        send_word(make_word(FUNC_RANGE,  10'd1023, 10'd0,    32'h0));
        send_word(make_word(FUNC_RANGE,  10'd300,  10'd300,  32'h0));
        send_word(make_word(FUNC_RANGE,  10'd1,    10'd768,  32'h0));
        send_word(make_word(FUNC_RANGE,  10'd511,  10'd1023, 32'h0));
        // spare func code leaves the tree untouched
        send_word(make_word(FUNC_SPARE,  10'd1,    10'd1023, 32'hFFFF_FFFF));
        send_word(make_word(FUNC_PREFIX, 10'd1023, 10'd0,    32'h0));
        send_word(make_word(FUNC_UPDATE, 10'd1,    10'd0,    32'h0000_0001));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == HOLD_START) begin
                back_to_back = 1'b1;
                hold_req     = 1'b1;
            end
            if (n == HOLD_START + HOLD_WORDS)
                back_to_back = 1'b0;
            if (n == RANDOM_WORDS - QUIET_WORDS)
                quiet = 1'b1;
            send_word(random_word());
        end
        in_if.valid <= 1'b0;

        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
